### hw/rtl/uth_pkg.sv
// Package for the UTF-8 to UCS-2 hex encoder: payload structs, lead-byte
// constants and the nibble-to-ASCII function.
// No dependencies.
package uth_pkg;

  // One input byte request
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  // One hex character result
  typedef struct packed {
    logic [6:0] hex_char;
    logic       unit_done;
    logic       text_done;
  } hex_item_t;

  // Completed code unit passed from front to back
  typedef struct packed {
    logic [15:0] code;
    logic        last;
  } code_unit_t;

  // Continuation bytes still expected
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  // Lead of a two-byte sequence: 110xxxxx
  localparam logic [2:0] LEAD2_MARK = 3'b110;

  // Digit position of the last hex character of a unit
  localparam logic [1:0] LAST_DIGIT = 2'd3;

  function automatic logic [6:0] hex_ascii(input logic [3:0] nib);
    logic [6:0] ch;
    case (nib)
      4'h0: ch = 7'h30;
      4'h1: ch = 7'h31;
      4'h2: ch = 7'h32;
      4'h3: ch = 7'h33;
      4'h4: ch = 7'h34;
      4'h5: ch = 7'h35;
      4'h6: ch = 7'h36;
      4'h7: ch = 7'h37;
      4'h8: ch = 7'h38;
      4'h9: ch = 7'h39;
      4'hA: ch = 7'h41;
      4'hB: ch = 7'h42;
      4'hC: ch = 7'h43;
      4'hD: ch = 7'h44;
      4'hE: ch = 7'h45;
      default: ch = 7'h46;
    endcase
    return ch;
  endfunction

endpackage

### hw/rtl/uth_front.sv
// Front end: accepts UTF-8 bytes, tracks the open sequence and assembles
// 16-bit code units. Depends on uth_pkg.
module uth_front import uth_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  text_item_t text_in,
  output logic       unit_push,
  input  logic       unit_full,
  output code_unit_t unit_out
);

  logic [1:0]  pending;
  logic [1:0]  pending_next;
  logic [15:0] acc;
  logic [15:0] acc_next;
  logic        unit_ready;
  logic        accept;
  logic [7:0]  b;

  assign b      = text_in.text_byte;
  assign full   = unit_full;
  assign accept = push && !full;

  // Sequence decode
  always_comb begin
    pending_next = pending;
    acc_next     = acc;
    unit_ready   = 1'b0;
    unique case (pending)
      PEND_NONE: begin
        if (!b[7]) begin
          acc_next   = {8'h00, b};
          unit_ready = 1'b1;
        end else if (b[7:5] == LEAD2_MARK) begin
          acc_next     = {5'b0, b[4:0], 6'b0};
          pending_next = PEND_ONE;
        end else begin
          // any other lead, stray continuation included: three-byte form
          acc_next     = {b[3:0], 12'b0};
          pending_next = PEND_TWO;
        end
      end
      PEND_ONE: begin
        acc_next     = acc | {10'b0, b[5:0]};
        pending_next = PEND_NONE;
        unit_ready   = 1'b1;
      end
      PEND_TWO: begin
        acc_next     = acc | {4'b0, b[5:0], 6'b0};
        pending_next = PEND_ONE;
      end
      default: begin
        pending_next = PEND_NONE;
      end
    endcase
    // text ends mid-sequence: flush with missing bytes as zero
    if (text_in.end_of_text && pending_next != PEND_NONE) begin
      pending_next = PEND_NONE;
      unit_ready   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= PEND_NONE;
      acc     <= '0;
    end else if (accept) begin
      pending <= pending_next;
      acc     <= acc_next;
    end
  end

  assign unit_push     = accept && unit_ready;
  assign unit_out.code = acc_next;
  assign unit_out.last = text_in.end_of_text;

  // Checks
  a_pend_range: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3) else $error("pending count out of range");
  a_eot_closes: assert property (@(posedge clk) disable iff (rst)
    (accept && text_in.end_of_text) |=> pending == PEND_NONE)
    else $error("sequence still open after end of text");
  a_eot_unit: assert property (@(posedge clk) disable iff (rst)
    (accept && text_in.end_of_text) |-> unit_push)
    else $error("end of text produced no unit");

endmodule

### hw/rtl/uth_queue.sv
// Short register queue of code units between the front and back ends.
// Depends on uth_pkg.
module uth_queue import uth_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  code_unit_t wr_data,
  output logic       q_full,
  input  logic       rd_en,
  output code_unit_t rd_data,
  output logic       q_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  code_unit_t           entries [DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;
  logic                 do_wr;
  logic                 do_rd;

  assign q_full  = (count == CNT_W'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Checks
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue overfilled");
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !q_full) else $error("unit pushed into full queue");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> count == $past(count) + 1'b1)
    else $error("fill count not updated on write");

endmodule

### hw/rtl/uth_back.sv
// Back end: takes code units from the queue and hands out four hex
// characters per unit, high nibble first. Depends on uth_pkg.
module uth_back import uth_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  code_unit_t q_data,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output hex_item_t  hex_out
);

  code_unit_t cur;
  logic [1:0] digit;
  logic       busy;
  logic       take;
  logic       load;
  logic [3:0] nib;

  assign take  = busy && pop;
  assign load  = !q_empty && (!busy || (take && digit == LAST_DIGIT));
  assign q_pop = load;
  assign empty = !busy;

  // Unit register and digit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      digit <= '0;
    end else if (load) begin
      busy  <= 1'b1;
      digit <= '0;
    end else if (take) begin
      if (digit == LAST_DIGIT) begin
        busy <= 1'b0;
      end
      digit <= digit + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_data;
    end
  end

  // Nibble select, high first
  always_comb begin
    case (digit)
      2'd0:    nib = cur.code[15:12];
      2'd1:    nib = cur.code[11:8];
      2'd2:    nib = cur.code[7:4];
      default: nib = cur.code[3:0];
    endcase
  end

  assign hex_out.hex_char  = hex_ascii(nib);
  assign hex_out.unit_done = (digit == LAST_DIGIT);
  assign hex_out.text_done = (digit == LAST_DIGIT) && cur.last;

  // Checks
  a_idle_digit: assert property (@(posedge clk) disable iff (rst)
    !busy |-> digit == '0) else $error("digit counter moved while idle");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (busy && !pop) |=> busy && $stable(digit))
    else $error("result changed without a pop");
  a_text_done: assert property (@(posedge clk) disable iff (rst)
    hex_out.text_done |-> hex_out.unit_done)
    else $error("text end flagged off a unit boundary");

endmodule

### hw/rtl/utf8_to_ucs2_hex_encoder_top.sv
// Top level of the UTF-8 to UCS-2 hex encoder: front decoder, unit queue
// and hex back end. Depends on uth_pkg, uth_front, uth_queue, uth_back.
//
//  channel   direction  handshake     payload
//  input     in         push / full   text_in  (text_item_t)
//  result    out        pop / empty   hex_out  (hex_item_t)
//
// A byte is taken every cycle while the unit queue has room; one that
// completes a code unit yields four characters, one per cycle while pop
// is held high, so the sustained rate is set by the back end.
// Lead bytes of multi-byte sequences yield nothing unless they end a text.
// Reset (rst, synchronous) empties the queue and closes any open sequence.
// A stalled result side fills the queue, then full rises.
module utf8_to_ucs2_hex_encoder_top import uth_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  text_item_t text_in,
  output logic       empty,
  input  logic       pop,
  output hex_item_t  hex_out
);

  logic       unit_push;
  logic       unit_full;
  code_unit_t unit_wr;
  logic       q_pop;
  logic       q_empty;
  code_unit_t q_data;

  uth_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .text_in   (text_in),
    .unit_push (unit_push),
    .unit_full (unit_full),
    .unit_out  (unit_wr)
  );

  uth_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (unit_push),
    .wr_data (unit_wr),
    .q_full  (unit_full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .q_empty (q_empty)
  );

  uth_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .hex_out (hex_out)
  );

endmodule

### dv/tb_top.sv
// Self-checking testbench for utf8_to_ucs2_hex_encoder_top: drives UTF-8 bytes,
// predicts the hex characters and checks every character popped from the block.
// Depends on uth_pkg and the encoder RTL.
module tb_top import uth_pkg::*; ();

  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_BYTES = 125;
  localparam int DRAIN_CYCLES = 20;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  text_item_t text_in;
  logic       empty;
  logic       pop;
  hex_item_t  hex_out;

  // Decoder state mirrored by the predictor
  logic [1:0]  pend_cnt;
  logic [15:0] unit_acc;
  hex_item_t   hex_expect_q[$];
  hex_item_t   want;

  int  fail_count;
  int  bytes_sent;
  int  chars_checked;
  int  full_cycles;
  int  idle_cycles;
  int  burst_left;
  bit  no_gaps;
  bit  hold_req;

  logic [15:0] pop_pattern;
  int          pop_phase;

  utf8_to_ucs2_hex_encoder_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .text_in (text_in),
    .empty   (empty),
    .pop     (pop),
    .hex_out (hex_out)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ASCII code of one uppercase hex digit
  function automatic logic [6:0] nibble_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 7'h30 + {3'b000, nib};
    end
    return 7'h37 + {3'b000, nib};
  endfunction

  // Advance the decoder by one byte and queue the characters it yields
  function automatic void predict_byte(input text_item_t it);
    logic [7:0] b;
    logic       ready;
    hex_item_t  ch;
    b = it.text_byte;
    ready = 1'b0;
    if (pend_cnt == PEND_NONE) begin
      if (!b[7]) begin
        unit_acc = {8'h00, b};
        ready = 1'b1;
      end else if (b[7:5] == LEAD2_MARK) begin
        unit_acc = {5'b00000, b[4:0], 6'b000000};
        pend_cnt = PEND_ONE;
      end else begin
        // stray continuation and four-byte leads land here too
        unit_acc = {b[3:0], 12'h000};
        pend_cnt = PEND_TWO;
      end
    end else if (pend_cnt == PEND_ONE) begin
      unit_acc = unit_acc | {10'b0, b[5:0]};
      pend_cnt = PEND_NONE;
      ready = 1'b1;
    end else begin
      unit_acc = unit_acc | {4'b0, b[5:0], 6'b0};
      pend_cnt = PEND_ONE;
    end
    // text cut short: missing continuation bits stay zero
    if (it.end_of_text && pend_cnt != PEND_NONE) begin
      pend_cnt = PEND_NONE;
      ready = 1'b1;
    end
    if (ready) begin
      for (int k = 0; k < 4; k++) begin
        ch.hex_char  = nibble_char(unit_acc[15 - 4 * k -: 4]);
        ch.unit_done = (k == 3);
        ch.text_done = (k == 3) && it.end_of_text;
        hex_expect_q.insert(hex_expect_q.size(), ch);
      end
    end
  endfunction

  // Send one byte request; entered and left at a falling edge, push left high
  task automatic send_byte(input logic [7:0] b, input logic eot);
    text_item_t it;
    int gap;
    it.text_byte   = b;
    it.end_of_text = eot;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (!no_gaps && gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    push    <= 1'b1;
    text_in <= it;
    do @(posedge clk); while (full);
    predict_byte(it);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic test_ascii();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h41, 1'b0);
  endtask

  task automatic test_two_byte();
    send_byte(8'hC2, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_three_byte();
    send_byte(8'hE0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  // Stray continuation and four-byte leads act as three-byte leads
  task automatic test_odd_leads();
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'h3F, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // Text ending inside a sequence, then a fresh text
  task automatic test_truncated();
    send_byte(8'hC3, 1'b1);
    send_byte(8'hE2, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(8'h41, 1'b1);
  endtask

  // Mostly well-formed sequences with random payload, some noise and cut texts
  task automatic test_random();
    logic [7:0] burst_bytes [3];
    int kind;
    int len;
    int stop;
    int sent;
    bit ends;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        burst_bytes[0] = {1'b0, 7'($urandom_range(0, 127))};
        len = 1;
      end else if (kind <= 5) begin
        burst_bytes[0] = {LEAD2_MARK, 5'($urandom_range(0, 31))};
        burst_bytes[1] = {2'b10, 6'($urandom_range(0, 63))};
        len = 2;
      end else if (kind <= 8) begin
        burst_bytes[0] = ($urandom_range(0, 4) == 0) ? {5'b11110, 3'($urandom_range(0, 7))}
                                                     : {4'b1110, 4'($urandom_range(0, 15))};
        burst_bytes[1] = {2'b10, 6'($urandom_range(0, 63))};
        burst_bytes[2] = {2'b10, 6'($urandom_range(0, 63))};
        len = 3;
      end else begin
        burst_bytes[0] = 8'($urandom_range(0, 255));
        len = 1;
      end
      // occasionally corrupt a continuation byte
      if (len > 1 && $urandom_range(0, 9) == 0) begin
        burst_bytes[len - 1] = 8'($urandom_range(0, 255));
      end
      ends = ($urandom_range(0, 5) == 0);
      stop = len - 1;
      if (ends && $urandom_range(0, 3) == 0) begin
        stop = $urandom_range(0, len - 1);
      end
      for (int i = 0; i <= stop; i++) begin
        send_byte(burst_bytes[i], ends && (i == stop));
        sent++;
      end
    end
  endtask

  // Receiver holds off while bytes keep coming, so full must rise
  task automatic test_backpressure();
    hold_req = 1'b1;
    no_gaps  = 1'b1;
    for (int i = 0; i < 24; i++) begin
      send_byte(8'($urandom_range(0, 127)), (i == 23));
    end
    no_gaps = 1'b0;
  endtask

  // Receiver: long hold when asked, otherwise a rotating stall pattern
  always @(negedge clk) begin
    if (hold_req) begin
      pop <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_req = 1'b0;
    end else begin
      if (pop_phase == 0) begin
        pop_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
        if (pop_pattern == 16'h0000) begin
          pop_pattern = 16'h0001;
        end
        pop_phase = 48;
      end
      pop <= pop_pattern[0];
      pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
      pop_phase--;
    end
  end

  // Result check against the oldest expected character
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (hex_expect_q.size() == 0) begin
        $error("unexpected hex character %h", hex_out.hex_char);
        fail_count++;
      end else begin
        want = hex_expect_q.pop_front();
        if (hex_out.hex_char !== want.hex_char) begin
          $error("hex_char expected %h actual %h", want.hex_char, hex_out.hex_char);
          fail_count++;
        end
        if (hex_out.unit_done !== want.unit_done) begin
          $error("unit_done expected %b actual %b", want.unit_done, hex_out.unit_done);
          fail_count++;
        end
        if (hex_out.text_done !== want.text_done) begin
          $error("text_done expected %b actual %b", want.text_done, hex_out.text_done);
          fail_count++;
        end
      end
      chars_checked++;
    end
  end

  // Watchdog on cycles with no request moving either way
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
    if (!rst && push && full) begin
      full_cycles++;
    end
  end

  initial begin
    rst         = 1'b1;
    push        = 1'b0;
    pop         = 1'b0;
    text_in     = '0;
    pend_cnt    = PEND_NONE;
    unit_acc    = 16'h0000;
    fail_count  = 0;
    bytes_sent  = 0;
    chars_checked = 0;
    full_cycles = 0;
    burst_left  = 0;
    no_gaps     = 1'b0;
    hold_req    = 1'b0;
    pop_phase   = 0;
    pop_pattern = 16'hFFFF;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_ascii();
    test_two_byte();
    test_three_byte();
    test_odd_leads();
    test_truncated();
    test_random();
    test_backpressure();
    test_random();

    // Drain everything still owed
    push <= 1'b0;
    wait (hex_expect_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (hex_expect_q.size() != 0) begin
      $error("%0d expected hex characters never arrived", hex_expect_q.size());
      fail_count++;
    end

    $display("Sent %0d UTF-8 bytes, checked %0d hex characters", bytes_sent, chars_checked);
    $display("Input held off by full on %0d cycles", full_cycles);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
